// ===== rtl/abfb_pkg.sv =====
// Shared types, constants and helpers for the alpha blend framebuffer.
package abfb_pkg;

	localparam int STORE_WIDTH_DEF  = 512;
	localparam int STORE_HEIGHT_DEF = 256;

	localparam int VW_BITS = 10;
	localparam int VH_BITS = 9;
	localparam logic [VW_BITS-1:0] VIS_WIDTH_RST  = 10'd320;
	localparam logic [VH_BITS-1:0] VIS_HEIGHT_RST = 9'd200;

	localparam logic [0:0] REG_VIS_WIDTH  = 1'b0;
	localparam logic [0:0] REG_VIS_HEIGHT = 1'b1;

	localparam int PIX_BITS = 24;
	localparam logic [7:0] OPAQUE_TOP = 8'hff;

	typedef enum logic [1:0] {
		OP_BLEND = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_MIX,
		ST_FILL,
		ST_PUSH
	} state_t;

	// Exact floor(v / 255) for any v up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = 17'(v) + 17'(v[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [31:0] opaque_word(input logic [PIX_BITS-1:0] pix);
		return {OPAQUE_TOP, pix};
	endfunction

endpackage

// ===== rtl/abfb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module abfb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 131072,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/abfb_mix.sv =====
// Blend datapath: registered channel products, then sum and divide by 255.
module abfb_mix (
	input  logic                          clk,
	input  logic                          load,
	input  logic [7:0]                    alpha,
	input  logic [abfb_pkg::PIX_BITS-1:0] src,
	input  logic [abfb_pkg::PIX_BITS-1:0] dst,
	output logic [abfb_pkg::PIX_BITS-1:0] mixed
);
	import abfb_pkg::*;

	logic [15:0] src_prod_s1 [3];
	logic [15:0] dst_prod_s1 [3];
	logic [7:0]  inv_alpha;

	assign inv_alpha = 8'd255 - alpha;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [15:0] sum;

		always_ff @(posedge clk) begin
			if (load) begin
				src_prod_s1[c] <= 16'(alpha) * 16'(src[8*c +: 8]);
				dst_prod_s1[c] <= 16'(inv_alpha) * 16'(dst[8*c +: 8]);
			end
		end

		// The two products always add up to at most 255 * 255.
		assign sum = src_prod_s1[c] + dst_prod_s1[c];
		assign mixed[8*c +: 8] = div255(sum);
	end

endmodule

// ===== rtl/alpha_blend_framebuffer_unit.sv =====
// Top level of the alpha blend framebuffer: control, clipping and result register.
// From input beat to result beat: read passes RD and PUSH, blend RD, MIX and PUSH, a
// clipped or unused op PUSH alone, a clear FILL over visible width * visible height, with
// both sizes clamped to the store, then PUSH. One item is worked at a time; the next is
// taken once the result is in the output register. The rate is set by the single RAM port
// pair and its registered read. After reset a clearing pass zeroes all STORE_WIDTH *
// STORE_HEIGHT entries; s_tready stays low until it ends, config writes are taken.
module alpha_blend_framebuffer_unit #(
	parameter int STORE_WIDTH  = abfb_pkg::STORE_WIDTH_DEF,
	parameter int STORE_HEIGHT = abfb_pkg::STORE_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// x_pos[15:0], y_pos[31:16], red[39:32], green[47:40], blue[55:48], alpha[63:56]
	input  logic [63:0]                  s_tdata,
	// op[1:0]
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// pixel_word[31:0]
	output logic [31:0]                  m_tdata,
	// clipped[0]
	output logic                         m_tuser,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [abfb_pkg::VW_BITS-1:0] cfg_data
);
	import abfb_pkg::*;

	localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(STORE_WIDTH);
	localparam int YW    = $clog2(STORE_HEIGHT);

	state_t state_q, state_d;

	logic [VW_BITS-1:0] vis_w_q;
	logic [VH_BITS-1:0] vis_h_q;

	op_t                op_q;
	logic [PIX_BITS-1:0] rgb_q;
	logic [7:0]         alpha_q;
	logic [AW-1:0]      addr_q;
	logic [31:0]        res_q;
	logic               clip_q;
	logic [XW-1:0]      fx_q;
	logic [YW-1:0]      fy_q;
	logic [AW-1:0]      row_q;
	logic [AW-1:0]      init_q;

	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;
	logic               m_tuser_q;

	logic [15:0]        in_x, in_y;
	logic [PIX_BITS-1:0] in_rgb;
	op_t                in_op;
	logic [15:0]        eff_w, eff_h;
	logic               in_vis;
	logic [AW-1:0]      in_addr;
	logic               accept;
	logic               out_free;
	logic               fill_row_end, fill_last;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr;
	logic [PIX_BITS-1:0] mem_wdata, mem_rdata, mix_out;
	logic               mix_load;

	assign in_x   = s_tdata[15:0];
	assign in_y   = s_tdata[31:16];
	assign in_rgb = {s_tdata[55:48], s_tdata[47:40], s_tdata[39:32]};
	assign in_op  = op_t'(s_tuser);

	assign eff_w = (16'(vis_w_q) < 16'(STORE_WIDTH))  ? 16'(vis_w_q) : 16'(STORE_WIDTH);
	assign eff_h = (16'(vis_h_q) < 16'(STORE_HEIGHT)) ? 16'(vis_h_q) : 16'(STORE_HEIGHT);

	// A negative coordinate has its sign bit set, so the unsigned compare covers it too.
	assign in_vis  = !in_x[15] && !in_y[15] && (in_x < eff_w) && (in_y < eff_h);
	assign in_addr = AW'(in_y[YW-1:0]) * AW'(STORE_WIDTH) + AW'(in_x[XW-1:0]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign fill_row_end = (16'(fx_q) + 16'd1) == eff_w;
	assign fill_last    = fill_row_end && ((16'(fy_q) + 16'd1) == eff_h);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	abfb_ram #(
		.WIDTH(PIX_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(in_addr),
		.rdata(mem_rdata)
	);

	abfb_mix u_mix (
		.clk  (clk),
		.load (mix_load),
		.alpha(alpha_q),
		.src  (rgb_q),
		.dst  (mem_rdata),
		.mixed(mix_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mix_out;
		mix_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q;
				mem_wdata = '0;
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_BLEND, OP_READ: begin
							if (in_vis) begin
								mem_re  = 1'b1;
								state_d = ST_RD;
							end else begin
								state_d = ST_PUSH;
							end
						end
						OP_CLEAR: begin
							if (eff_w == 16'd0 || eff_h == 16'd0) begin
								state_d = ST_PUSH;
							end else begin
								state_d = ST_FILL;
							end
						end
						default: state_d = ST_PUSH;
					endcase
				end
			end
			ST_RD: begin
				if (op_q == OP_READ) begin
					state_d = ST_PUSH;
				end else begin
					mix_load = 1'b1;
					state_d  = ST_MIX;
				end
			end
			ST_MIX: begin
				mem_we  = 1'b1;
				state_d = ST_PUSH;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = row_q + AW'(fx_q);
				mem_wdata = rgb_q;
				if (fill_last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Configuration registers, loop counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_w_q    <= VIS_WIDTH_RST;
			vis_h_q    <= VIS_HEIGHT_RST;
			init_q     <= '0;
			fx_q       <= '0;
			fy_q       <= '0;
			row_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VIS_WIDTH:  vis_w_q <= cfg_data;
					REG_VIS_HEIGHT: vis_h_q <= cfg_data[VH_BITS-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_INIT) begin
				init_q <= init_q + AW'(1);
			end
			if (accept) begin
				fx_q  <= '0;
				fy_q  <= '0;
				row_q <= '0;
			end else if (state_q == ST_FILL) begin
				if (fill_row_end) begin
					fx_q  <= '0;
					fy_q  <= fy_q + YW'(1);
					row_q <= row_q + AW'(STORE_WIDTH);
				end else begin
					fx_q <= fx_q + XW'(1);
				end
			end
			if (state_q == ST_PUSH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Item payload and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_op;
			rgb_q   <= in_rgb;
			alpha_q <= s_tdata[63:56];
			addr_q  <= in_addr;
			case (in_op)
				OP_BLEND, OP_READ: begin
					res_q  <= '0;
					clip_q <= !in_vis;
				end
				OP_CLEAR: begin
					res_q  <= opaque_word(in_rgb);
					clip_q <= 1'b0;
				end
				default: begin
					res_q  <= '0;
					clip_q <= 1'b0;
				end
			endcase
		end else if (state_q == ST_RD && op_q == OP_READ) begin
			res_q <= opaque_word(mem_rdata);
		end else if (state_q == ST_MIX) begin
			res_q <= opaque_word(mix_out);
		end
		if (state_q == ST_PUSH && out_free) begin
			m_tdata_q <= res_q;
			m_tuser_q <= clip_q;
		end
	end

endmodule

// ===== rtl/abfb_chk.sv =====
// Port-level checks for the alpha blend framebuffer, bound to the top level.
module abfb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A result that waits must not change under the consumer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A clipped result never carries a pixel.
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("clipped result with nonzero pixel word");

	// Every nonzero pixel word is opaque in its top byte.
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata != 32'd0) |-> m_tdata[31:24] == 8'hff)
		else $error("pixel word without opaque top byte");

	// Items are worked one at a time, so ready drops right after an input beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second input beat taken while an item is in work");

endmodule

bind alpha_blend_framebuffer_unit abfb_chk u_abfb_chk (.*);

// ===== tb/alpha_blend_framebuffer_unit_tb.sv =====
// Self-checking testbench for the alpha blend framebuffer: blend, read, clear and clipping.
module alpha_blend_framebuffer_unit_tb;

	import abfb_pkg::*;

	localparam int STORE_W = STORE_WIDTH_DEF;
	localparam int STORE_H = STORE_HEIGHT_DEF;
	// Longest quiet stretch is the clearing pass or a full-store clear, plus stalls.
	localparam int WATCHDOG_LIMIT = 500000;
	localparam int PHASE_ITEMS = 50;
	localparam int PHASE_COUNT = 10;

	typedef struct {
		op_t                op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic [7:0]         a;
	} pix_item_t;

	typedef struct {
		logic [31:0] word;
		logic        clip;
	} pix_due_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [63:0]         s_tdata = '0;
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [31:0]         m_tdata;
	logic                m_tuser;
	logic                cfg_we = 1'b0;
	logic [0:0]          cfg_index = '0;
	logic [VW_BITS-1:0]  cfg_data = '0;

	// Shadow copy of the frame store and of the two size registers.
	logic [PIX_BITS-1:0] frame_img [0:STORE_W*STORE_H-1];
	logic [VW_BITS-1:0]  vis_w_reg = VIS_WIDTH_RST;
	logic [VH_BITS-1:0]  vis_h_reg = VIS_HEIGHT_RST;

	pix_item_t blit_q[$];
	pix_due_t  pixel_due_q[$];
	pix_item_t cur_item;

	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_mode_left = 0;
	int ready_tick = 0;
	int quiet_cycles = 0;

	alpha_blend_framebuffer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] channel_mix(input logic [7:0] a, input logic [7:0] src,
			input logic [7:0] dst);
		int v;
		v = (int'(a) * int'(src) + (255 - int'(a)) * int'(dst)) / 255;
		return v[7:0];
	endfunction

	// Applies one beat to the shadow store and returns the result it must produce.
	function automatic pix_due_t frame_predict(input pix_item_t it);
		pix_due_t            d;
		int                  w;
		int                  h;
		int                  xs;
		int                  ys;
		int                  idx;
		logic [PIX_BITS-1:0] cur;
		logic [PIX_BITS-1:0] fill;
		d.word = '0;
		d.clip = 1'b0;
		w = (int'(vis_w_reg) < STORE_W) ? int'(vis_w_reg) : STORE_W;
		h = (int'(vis_h_reg) < STORE_H) ? int'(vis_h_reg) : STORE_H;
		xs = it.x;
		ys = it.y;
		case (it.op)
			OP_BLEND, OP_READ: begin
				if (xs < 0 || ys < 0 || xs >= w || ys >= h) begin
					d.clip = 1'b1;
				end else begin
					idx = ys * STORE_W + xs;
					cur = frame_img[idx];
					if (it.op == OP_BLEND) begin
						cur = {channel_mix(it.a, it.b, cur[23:16]),
							channel_mix(it.a, it.g, cur[15:8]),
							channel_mix(it.a, it.r, cur[7:0])};
						frame_img[idx] = cur;
					end
					d.word = {OPAQUE_TOP, cur};
				end
			end
			OP_CLEAR: begin
				fill = {it.b, it.g, it.r};
				for (int yy = 0; yy < h; yy++)
					for (int xx = 0; xx < w; xx++)
						frame_img[yy * STORE_W + xx] = fill;
				d.word = {OPAQUE_TOP, fill};
			end
			default: ;
		endcase
		return d;
	endfunction

	// Mostly in range; the upper bound itself sits one past the visible edge.
	function automatic logic [15:0] rand_coord(input int lim);
		int c;
		c = $urandom_range(0, 9);
		if (c < 7)
			return 16'($urandom_range(0, lim));
		else if (c < 9)
			return -16'($urandom_range(1, 3));
		return 16'($urandom);
	endfunction

	task automatic push_item(input op_t op, input logic [15:0] x, input logic [15:0] y,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a);
		pix_item_t it;
		it.op = op;
		it.x = x;
		it.y = y;
		it.r = r;
		it.g = g;
		it.b = b;
		it.a = a;
		blit_q.push_back(it);
	endtask

	task automatic cfg_write(input logic [0:0] idx, input logic [VW_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_VIS_WIDTH)
			vis_w_reg = val;
		else
			vis_h_reg = val[VH_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sampled on the falling edge so that all rising-edge updates have settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (blit_q.size() != 0 || s_tvalid || pixel_due_q.size() != 0);
	endtask

	// Sender: bursts of beats separated by random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				pixel_due_q.push_back(frame_predict(cur_item));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (blit_q.size() > 0) begin
					cur_item = blit_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_item.op;
					s_tdata <= {cur_item.a, cur_item.b, cur_item.g, cur_item.r,
						cur_item.y, cur_item.x};
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(0, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready follows a stall pattern that changes every so often.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_mode_left = $urandom_range(16, 200);
			end else begin
				stall_mode_left--;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (ready_tick % 4 != 0);
				default: m_tready <= (ready_tick % 5 == 0);
			endcase
			ready_tick++;
		end
	end

	always @(posedge clk) begin
		pix_due_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_due_q.size() == 0) begin
				$error("result beat with nothing expected: pixel_word %h clipped %b",
					m_tdata, m_tuser);
				errors++;
			end else begin
				due = pixel_due_q.pop_front();
				if (m_tdata !== due.word) begin
					$error("pixel_word expected %h actual %h", due.word, m_tdata);
					errors++;
				end
				if (m_tuser !== due.clip) begin
					$error("clipped expected %b actual %b", due.clip, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [VW_BITS-1:0] cw;
		logic [VW_BITS-1:0] ch;
		int                 ew;
		int                 eh;
		int                 sel;
		op_t                op;
		logic [15:0]        px;
		logic [15:0]        py;
		logic [7:0]         al;

		for (int i = 0; i < STORE_W * STORE_H; i++)
			frame_img[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes: 320 x 200. Blocked until the clearing pass ends.
		@(negedge clk);
		push_item(OP_READ, 16'd0, 16'd0, 8'hff, 8'hff, 8'hff, 8'hff);
		push_item(OP_BLEND, 16'd0, 16'd0, 8'hff, 8'h00, 8'h80, 8'hff);
		push_item(OP_BLEND, 16'd0, 16'd0, 8'h11, 8'h22, 8'h33, 8'h00);
		push_item(OP_BLEND, 16'd319, 16'd199, 8'hff, 8'hff, 8'hff, 8'h80);
		push_item(OP_READ, 16'd319, 16'd199, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_BLEND, 16'd320, 16'd0, 8'hff, 8'hff, 8'hff, 8'hff);
		push_item(OP_READ, 16'd0, 16'd200, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_BLEND, 16'hffff, 16'd5, 8'hff, 8'hff, 8'hff, 8'hff);
		push_item(OP_READ, 16'd5, 16'h8000, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_READ, 16'h7fff, 16'h7fff, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_NONE, 16'd3, 16'd3, 8'h5a, 8'ha5, 8'hff, 8'hff);
		push_item(OP_CLEAR, 16'hffff, 16'h8000, 8'h12, 8'h34, 8'h56, 8'h9c);
		push_item(OP_READ, 16'd5, 16'd5, 8'h00, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// Sizes beyond the store clamp to 512 x 256; height bit 9 is dropped.
		cfg_write(REG_VIS_WIDTH, 10'h3ff);
		cfg_write(REG_VIS_HEIGHT, 10'h3ff);
		@(negedge clk);
		push_item(OP_BLEND, 16'd511, 16'd255, 8'h80, 8'h40, 8'h20, 8'hc0);
		push_item(OP_READ, 16'd512, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_READ, 16'd0, 16'd256, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_READ, 16'd511, 16'd255, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_CLEAR, 16'd0, 16'd0, 8'hff, 8'hff, 8'hff, 8'hff);
		push_item(OP_READ, 16'd511, 16'd255, 8'h00, 8'h00, 8'h00, 8'h00);
		wait_idle();

		// Zero visible size: everything clips and a clear writes nothing.
		cfg_write(REG_VIS_WIDTH, 10'd0);
		cfg_write(REG_VIS_HEIGHT, 10'd0);
		@(negedge clk);
		push_item(OP_BLEND, 16'd0, 16'd0, 8'h01, 8'h02, 8'h03, 8'hff);
		push_item(OP_READ, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_CLEAR, 16'd0, 16'd0, 8'h0f, 8'hf0, 8'h3c, 8'h00);
		wait_idle();
		cfg_write(REG_VIS_WIDTH, 10'd8);
		cfg_write(REG_VIS_HEIGHT, 10'd8);
		@(negedge clk);
		push_item(OP_READ, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		push_item(OP_READ, 16'd7, 16'd7, 8'h00, 8'h00, 8'h00, 8'h00);
		wait_idle();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case ($urandom_range(0, 9))
				0: cw = 10'd0;
				1: cw = 10'd1;
				2: cw = 10'h3ff;
				3: cw = 10'd512;
				4: cw = 10'($urandom);
				default: cw = 10'($urandom_range(1, 24));
			endcase
			case ($urandom_range(0, 9))
				0: ch = 10'd0;
				1: ch = 10'd1;
				2: ch = 10'h1ff;
				3: ch = 10'd256;
				4: ch = 10'($urandom);
				default: ch = 10'($urandom_range(1, 24));
			endcase
			cfg_write(REG_VIS_WIDTH, cw);
			cfg_write(REG_VIS_HEIGHT, ch);
			ew = (int'(cw) < STORE_W) ? int'(cw) : STORE_W;
			eh = (int'(ch[VH_BITS-1:0]) < STORE_H) ? int'(ch[VH_BITS-1:0]) : STORE_H;
			@(negedge clk);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(0, 99);
				px = rand_coord(ew);
				py = rand_coord(eh);
				if (sel < 55) begin
					op = OP_BLEND;
				end else if (sel < 80) begin
					op = OP_READ;
				end else if (sel < 86) begin
					op = OP_CLEAR;
				end else if (sel < 92) begin
					op = OP_NONE;
				end else begin
					op = op_t'($urandom_range(0, 3));
					px = 16'($urandom);
					py = 16'($urandom);
				end
				// Large clears would dominate the run time.
				if (op == OP_CLEAR && ew * eh > 1024)
					op = OP_READ;
				case ($urandom_range(0, 7))
					0: al = 8'h00;
					1: al = 8'hff;
					default: al = 8'($urandom);
				endcase
				push_item(op, px, py, 8'($urandom), 8'($urandom), 8'($urandom), al);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && pixel_due_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
